FILE: design/ipv4_five_tuple_parser_assert.svh
// assertion macros shared by the parser checks
`ifndef IPV4_FIVE_TUPLE_PARSER_ASSERT_SVH
`define IPV4_FIVE_TUPLE_PARSER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define IP5T_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("parser check failed");

// next-cycle implication, off while reset is asserted
`define IP5T_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("parser check failed");

`endif

FILE: design/ip5t_pkg.sv
`timescale 1ns / 1ps

package ip5t_pkg;

	// link modes
	localparam logic [1:0] LINK_RAW  = 2'd0;
	localparam logic [1:0] LINK_ETH  = 2'd1;
	localparam logic [1:0] LINK_VLAN = 2'd2;

	// link layer lengths
	localparam logic [7:0] ETH_LEN  = 8'd14;
	localparam logic [7:0] VLAN_LEN = 8'd18;

	// fixed header offsets and sizes
	localparam logic [7:0] OFF_OUTER_HI = 8'd12;
	localparam logic [7:0] OFF_OUTER_LO = 8'd13;
	localparam logic [7:0] OFF_INNER_HI = 8'd16;
	localparam logic [7:0] OFF_INNER_LO = 8'd17;
	localparam logic [7:0] IP_PROTO_OFF = 8'd9;
	localparam logic [7:0] IP_SRC_OFF   = 8'd12;
	localparam logic [7:0] IP_DST_OFF   = 8'd16;
	localparam logic [7:0] IP_MIN       = 8'd20;
	localparam logic [7:0] TCP_LEN      = 8'd20;
	localparam logic [7:0] UDP_LEN      = 8'd8;

	localparam logic [15:0] TYPE_IP   = 16'h0800;
	localparam logic [15:0] TYPE_VLAN = 16'h8100;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [3:0]  IP_V4     = 4'd4;

	typedef enum logic [2:0] {
		DROP_NONE      = 3'd0,
		DROP_SHORT_IP  = 3'd1,
		DROP_LINK_TYPE = 3'd2,
		DROP_VERSION   = 3'd3,
		DROP_SHORT_HDR = 3'd4,
		DROP_SHORT_L4  = 3'd5
	} drop_code_t;

	// result transaction, first field in the highest bits
	typedef struct packed {
		logic [5:0]  pad;
		logic [6:0]  header_len;
		logic [7:0]  protocol;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
		drop_code_t  drop_code;
	} result_t;

	localparam int OUT_W = $bits(result_t);

endpackage

FILE: design/ipv4_five_tuple_parser.sv
`timescale 1ns / 1ps

// IPv4 five-tuple parser. Feed one packet byte per transaction on the s_ side with s_tlast on
// the final byte; one result transaction per packet comes out on the m_ side when that last
// byte has been processed. Bytes are taken at one per cycle unless a last byte waits on a stalled
// result: each byte passes an input register, then updates the header capture registers, and the
// result register on the output lets the next packet stream in while a result waits. A result
// is written to the result register once its last byte leaves the input register. link_mode comes from the cfg_
// write channel and is meant to be written between packets; mode three acts as the tagged
// Ethernet mode. Addresses and ports are in network byte order, ports are zero for
// protocols other than TCP and UDP, and a dropped packet shows only its drop code.
module ipv4_five_tuple_parser import ip5t_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_data,   // link_mode
	// byte stream in
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,    // data_byte
	input  logic             s_tlast,    // last_byte
	// result out
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata     // drop_code, src_addr, dst_addr, sport,
	                                     // dport, protocol, header_len, zero pad
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [1:0] link_mode_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;
	logic       out_free;

	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [15:0] outer_q, outer_n;
	logic [15:0] inner_q, inner_n;
	logic [7:0]  vl_q, vl_n;
	logic [7:0]  proto_q, proto_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [15:0] sport_q, sport_n;
	logic [15:0] dport_q, dport_n;

	logic [7:0]  link_len;
	logic [7:0]  hl;
	logic [7:0]  port_off;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_n;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= LINK_RAW;
		end else if (cfg_valid) begin
			link_mode_q <= cfg_data;
		end
	end

	// input register
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// link layer length
	always_comb begin
		unique case (link_mode_q)
			LINK_RAW: link_len = 8'd0;
			LINK_ETH: link_len = ETH_LEN;
			default:  link_len = VLAN_LEN;
		endcase
	end

	// header capture at the current byte offset
	always_comb begin
		outer_n = outer_q;
		inner_n = inner_q;
		vl_n    = vl_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		sport_n = sport_q;
		dport_n = dport_q;

		if (count_q == COUNT_BITS'(OFF_OUTER_HI) || count_q == COUNT_BITS'(OFF_OUTER_LO)) begin
			outer_n = {outer_q[7:0], byte_s1};
		end
		if (count_q == COUNT_BITS'(OFF_INNER_HI) || count_q == COUNT_BITS'(OFF_INNER_LO)) begin
			inner_n = {inner_q[7:0], byte_s1};
		end
		if (count_q == COUNT_BITS'(link_len)) begin
			vl_n = byte_s1;
		end
		if (count_q == COUNT_BITS'(link_len + IP_PROTO_OFF)) begin
			proto_n = byte_s1;
		end
		if (count_q >= COUNT_BITS'(link_len + IP_SRC_OFF)
				&& count_q < COUNT_BITS'(link_len + IP_DST_OFF)) begin
			src_n = {src_q[23:0], byte_s1};
		end
		if (count_q >= COUNT_BITS'(link_len + IP_DST_OFF)
				&& count_q < COUNT_BITS'(link_len + IP_MIN)) begin
			dst_n = {dst_q[23:0], byte_s1};
		end

		// port offset follows the header length, including one taken this byte
		hl       = {2'b00, vl_n[3:0], 2'b00};
		port_off = link_len + hl;
		if (count_q >= COUNT_BITS'(port_off) && count_q < COUNT_BITS'(port_off + 8'd2)) begin
			sport_n = {sport_q[7:0], byte_s1};
		end
		if (count_q >= COUNT_BITS'(port_off + 8'd2)
				&& count_q < COUNT_BITS'(port_off + 8'd4)) begin
			dport_n = {dport_q[7:0], byte_s1};
		end

		count_n = (count_q < COUNT_MAX) ? count_q + 1'b1 : count_q;
	end

	// drop checks in priority order and result assembly
	always_comb begin
		res_n            = '0;
		res_n.drop_code  = DROP_NONE;
		res_n.header_len = hl[6:0];

		if (count_n < COUNT_BITS'(link_len + IP_MIN)) begin
			res_n.drop_code = DROP_SHORT_IP;
		end else if (link_mode_q == LINK_ETH && outer_n != TYPE_IP) begin
			res_n.drop_code = DROP_LINK_TYPE;
		end else if (link_mode_q[1] && (outer_n != TYPE_VLAN || inner_n != TYPE_IP)) begin
			res_n.drop_code = DROP_LINK_TYPE;
		end else if (vl_n[7:4] != IP_V4) begin
			res_n.drop_code = DROP_VERSION;
		end else if (count_n < COUNT_BITS'(port_off)) begin
			res_n.drop_code = DROP_SHORT_HDR;
		end else if (proto_n == PROTO_TCP) begin
			if (count_n < COUNT_BITS'(port_off + TCP_LEN)) begin
				res_n.drop_code = DROP_SHORT_L4;
			end
			res_n.header_len = 7'(hl + TCP_LEN);
			res_n.sport      = sport_n;
			res_n.dport      = dport_n;
		end else if (proto_n == PROTO_UDP) begin
			if (count_n < COUNT_BITS'(port_off + UDP_LEN)) begin
				res_n.drop_code = DROP_SHORT_L4;
			end
			res_n.header_len = 7'(hl + UDP_LEN);
			res_n.sport      = sport_n;
			res_n.dport      = dport_n;
		end

		if (res_n.drop_code == DROP_NONE) begin
			res_n.src_addr = src_n;
			res_n.dst_addr = dst_n;
			res_n.protocol = proto_n;
		end else begin
			res_n.header_len = '0;
			res_n.sport      = '0;
			res_n.dport      = '0;
		end
	end

	// per-packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			outer_q <= '0;
			inner_q <= '0;
			vl_q    <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				count_q <= '0;
				outer_q <= '0;
				inner_q <= '0;
				vl_q    <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				count_q <= count_n;
				outer_q <= outer_n;
				inner_q <= inner_n;
				vl_q    <= vl_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

endmodule

FILE: design/ip5t_checker.sv
`timescale 1ns / 1ps

`include "ipv4_five_tuple_parser_assert.svh"

module ip5t_checker import ip5t_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	result_t res;
	logic    is_l4;
	logic    out_stall;
	logic    dropped;
	logic    kept_plain;
	logic    kept_l4;
	logic    no_ports;
	logic    l4_len_ok;

	assign res        = m_tdata;
	assign is_l4      = res.protocol == PROTO_TCP || res.protocol == PROTO_UDP;
	assign out_stall  = m_tvalid && !m_tready;
	assign dropped    = m_tvalid && res.drop_code != DROP_NONE;
	assign kept_plain = m_tvalid && res.drop_code == DROP_NONE && !is_l4;
	assign kept_l4    = m_tvalid && res.drop_code == DROP_NONE && is_l4;
	assign no_ports   = res.sport == '0 && res.dport == '0 && res.header_len <= 7'd60;
	assign l4_len_ok  = res.header_len >= 7'd8 && res.header_len <= 7'd80;

	// a stalled result transaction holds
	`IP5T_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata))

	// a dropped packet carries nothing but its drop code
	`IP5T_ASSERT_IMP(a_drop_clean, clk, arst_n, dropped, m_tdata[OUT_W-1:3] == '0)

	// kept packets without a transport header have no ports and at most the IP header
	`IP5T_ASSERT_IMP(a_no_l4_ports, clk, arst_n, kept_plain, no_ports)

	// kept TCP or UDP packets keep at least the transport header
	`IP5T_ASSERT_IMP(a_l4_len, clk, arst_n, kept_l4, l4_len_ok)

endmodule

bind ipv4_five_tuple_parser ip5t_checker u_ip5t_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/ipv4_five_tuple_parser_tb.sv
`timescale 1ns / 1ps

module ipv4_five_tuple_parser_tb;
	import ip5t_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [1:0] LINK_VLAN_ALT = 2'd3;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [3:0] IP_V6 = 4'd6;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	byte_item_t pending_bytes[$];
	result_t    expected_results[$];

	int  bytes_pushed = 0;
	int  bytes_accepted = 0;
	int  packets_pushed = 0;
	int  results_seen = 0;
	int  kept_seen = 0;
	int  errors = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	bit  no_idle = 1'b0;

	// parser state as the block should hold it
	logic [1:0]  link_mode_q = LINK_RAW;
	logic [15:0] pkt_count = '0;
	logic [15:0] outer_q = '0;
	logic [15:0] inner_q = '0;
	logic [7:0]  vl_q = '0;
	logic [7:0]  proto_q = '0;
	logic [31:0] src_q = '0;
	logic [31:0] dst_q = '0;
	logic [15:0] sport_q = '0;
	logic [15:0] dport_q = '0;

	ipv4_five_tuple_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int link_bytes(input logic [1:0] mode);
		if (mode == LINK_RAW)
			return 0;
		if (mode == LINK_ETH)
			return int'(ETH_LEN);
		return int'(VLAN_LEN);
	endfunction

	// bytes needed for a complete ip plus l4 header in the current link mode
	function automatic int full_len(input int ihl, input logic [7:0] proto);
		int l;
		int need;
		l = link_bytes(link_mode_q);
		need = l + ihl * 4;
		if (proto == PROTO_TCP)
			need += int'(TCP_LEN);
		else if (proto == PROTO_UDP)
			need += int'(UDP_LEN);
		if (need < l + int'(IP_MIN))
			need = l + int'(IP_MIN);
		return need;
	endfunction

	// advance the parser by one accepted byte, queue a result on the last one
	task automatic parse_byte(input logic [7:0] b, input logic lst);
		int off;
		int l;
		int hl;
		int p;
		int cap;
		int hlen;
		logic [15:0] sp;
		logic [15:0] dp;
		drop_code_t code;
		result_t r;
		off = int'(pkt_count);
		l = link_bytes(link_mode_q);
		if (off == int'(OFF_OUTER_HI) || off == int'(OFF_OUTER_LO))
			outer_q = {outer_q[7:0], b};
		if (off == int'(OFF_INNER_HI) || off == int'(OFF_INNER_LO))
			inner_q = {inner_q[7:0], b};
		if (off == l)
			vl_q = b;
		if (off == l + int'(IP_PROTO_OFF))
			proto_q = b;
		if (off >= l + int'(IP_SRC_OFF) && off < l + int'(IP_SRC_OFF) + 4)
			src_q = {src_q[23:0], b};
		if (off >= l + int'(IP_DST_OFF) && off < l + int'(IP_DST_OFF) + 4)
			dst_q = {dst_q[23:0], b};

		// port bytes sit at ihl*4 from the ip start, even inside the fixed header
		hl = int'(vl_q[3:0]) * 4;
		p = l + hl;
		if (off >= p && off < p + 2)
			sport_q = {sport_q[7:0], b};
		if (off >= p + 2 && off < p + 4)
			dport_q = {dport_q[7:0], b};

		if (pkt_count != '1)
			pkt_count++;
		if (!lst)
			return;

		// drop checks, first failure wins
		cap = int'(pkt_count);
		code = DROP_NONE;
		hlen = hl;
		sp = '0;
		dp = '0;
		if (cap < l + int'(IP_MIN)) begin
			code = DROP_SHORT_IP;
		end else if (link_mode_q == LINK_ETH && outer_q != TYPE_IP) begin
			code = DROP_LINK_TYPE;
		end else if (link_mode_q >= LINK_VLAN && (outer_q != TYPE_VLAN || inner_q != TYPE_IP)) begin
			code = DROP_LINK_TYPE;
		end else if (vl_q[7:4] != IP_V4) begin
			code = DROP_VERSION;
		end else if (cap < l + hl) begin
			code = DROP_SHORT_HDR;
		end else if (proto_q == PROTO_TCP) begin
			if (cap < l + hl + int'(TCP_LEN))
				code = DROP_SHORT_L4;
			hlen = hl + int'(TCP_LEN);
			sp = sport_q;
			dp = dport_q;
		end else if (proto_q == PROTO_UDP) begin
			if (cap < l + hl + int'(UDP_LEN))
				code = DROP_SHORT_L4;
			hlen = hl + int'(UDP_LEN);
			sp = sport_q;
			dp = dport_q;
		end

		r = '0;
		r.drop_code = code;
		if (code == DROP_NONE) begin
			r.src_addr = src_q;
			r.dst_addr = dst_q;
			r.sport = sp;
			r.dport = dp;
			r.protocol = proto_q;
			r.header_len = 7'(hlen);
		end
		expected_results.insert(expected_results.size(), r);

		// per-packet state clears after the result
		pkt_count = '0;
		outer_q = '0;
		inner_q = '0;
		vl_q = '0;
		proto_q = '0;
		src_q = '0;
		dst_q = '0;
		sport_q = '0;
		dport_q = '0;
	endtask

	function automatic void put_byte(ref logic [7:0] pkt[], input int idx, input logic [7:0] v);
		if (idx < pkt.size())
			pkt[idx] = v;
	endfunction

	// build one packet for the current link mode and queue its bytes
	task automatic add_packet(input int ihl, input logic [3:0] ver, input logic [7:0] proto,
			input bit type_ok, input bit shaped, input int len, input int fill);
		logic [7:0] pkt[];
		byte_item_t item;
		int l;
		int k;
		int bad;
		int pick;
		l = link_bytes(link_mode_q);
		pkt = new[len];
		for (k = 0; k < len; k++)
			pkt[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
		if (shaped) begin
			if (link_mode_q == LINK_ETH) begin
				put_byte(pkt, int'(OFF_OUTER_HI), TYPE_IP[15:8]);
				put_byte(pkt, int'(OFF_OUTER_LO), TYPE_IP[7:0]);
			end else if (link_mode_q != LINK_RAW) begin
				put_byte(pkt, int'(OFF_OUTER_HI), TYPE_VLAN[15:8]);
				put_byte(pkt, int'(OFF_OUTER_LO), TYPE_VLAN[7:0]);
				put_byte(pkt, int'(OFF_INNER_HI), TYPE_IP[15:8]);
				put_byte(pkt, int'(OFF_INNER_LO), TYPE_IP[7:0]);
			end
			put_byte(pkt, l, {ver, 4'(ihl)});
			put_byte(pkt, l + int'(IP_PROTO_OFF), proto);
			// corrupt one ethertype or tag byte
			if (!type_ok && link_mode_q != LINK_RAW) begin
				pick = $urandom_range(0, 3);
				if (link_mode_q == LINK_ETH)
					bad = int'(OFF_OUTER_HI) + pick % 2;
				else
					bad = ((pick < 2) ? int'(OFF_OUTER_HI) : int'(OFF_INNER_HI)) + pick % 2;
				if (bad < len)
					pkt[bad] ^= 8'($urandom_range(1, 255));
			end
		end
		for (k = 0; k < len; k++) begin
			item.data = pkt[k];
			item.last = (k == len - 1);
			pending_bytes.insert(pending_bytes.size(), item);
			bytes_pushed++;
		end
		packets_pushed++;
	endtask

	// mostly well-formed headers with random content, some truncated, some noise
	task automatic add_random_packet(output int len);
		int ihl;
		int need;
		int pick;
		logic [3:0] ver;
		logic [7:0] proto;
		bit type_ok;
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
		ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_V4;
		pick = $urandom_range(0, 19);
		proto = (pick < 8) ? PROTO_TCP : (pick < 15) ? PROTO_UDP : 8'($urandom);
		type_ok = ($urandom_range(0, 9) != 0);
		need = full_len(ihl, proto);
		pick = $urandom_range(0, 9);
		if (pick <= 6)
			len = need + $urandom_range(0, 24);
		else if (pick <= 8)
			len = $urandom_range(1, need + 2);
		else
			len = $urandom_range(1, 40);
		add_packet(ihl, ver, proto, type_ok, pick <= 8, len, -1);
	endtask

	task automatic run_random(input int min_packets, input int min_bytes);
		int n;
		int total;
		int len;
		n = 0;
		total = 0;
		while (n < min_packets || total < min_bytes) begin
			add_random_packet(len);
			n++;
			total += len;
		end
	endtask

	// sender holds off until every byte is in and every result is out
	task automatic wait_idle();
		while (bytes_accepted != bytes_pushed || expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// link mode write, only with the parser idle
	task automatic set_link(input logic [1:0] mode);
		wait_idle();
		cfg_data <= mode;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		link_mode_q = mode;
	endtask

	// good, wrong link type and short packets for a link layer
	task automatic add_link_checks();
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b1, full_len(5, PROTO_TCP), -1);
		add_packet(5, IP_V4, PROTO_TCP, 1'b0, 1'b1, full_len(5, PROTO_TCP), -1);
		add_packet(5, IP_V4, PROTO_UDP, 1'b1, 1'b1,
			link_bytes(link_mode_q) + int'(IP_MIN) - 1, -1);
	endtask

	// byte sender
	always @(posedge clk) begin : drive_bytes
		byte_item_t cur;
		if (s_tvalid && s_tready) begin
			parse_byte(s_tdata, s_tlast);
			bytes_accepted++;
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				send_gap = $urandom_range(0, 10);
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				cur = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= cur.data;
				s_tlast <= cur.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
		end
	endtask

	// result receiver with random stalls
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result transaction with nothing expected, actual drop_code %0d",
					$time, got.drop_code);
			end else begin
				want = expected_results.pop_front();
				check_field("drop_code", 32'(want.drop_code), 32'(got.drop_code));
				check_field("src_addr", want.src_addr, got.src_addr);
				check_field("dst_addr", want.dst_addr, got.dst_addr);
				check_field("sport", 32'(want.sport), 32'(got.sport));
				check_field("dport", 32'(want.dport), 32'(got.dport));
				check_field("protocol", 32'(want.protocol), 32'(got.protocol));
				check_field("header_len", 32'(want.header_len), 32'(got.header_len));
				results_seen++;
				if (want.drop_code == DROP_NONE)
					kept_seen++;
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw ip straight out of reset
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b1, full_len(5, PROTO_TCP), -1);
		add_packet(5, IP_V4, PROTO_UDP, 1'b1, 1'b1, full_len(5, PROTO_UDP), -1);
		add_packet(5, IP_V4, PROTO_ICMP, 1'b1, 1'b1, full_len(5, PROTO_ICMP), -1);
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b1, 1, -1);
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b1, int'(IP_MIN) - 1, -1);
		add_packet(5, IP_V6, PROTO_TCP, 1'b1, 1'b1, full_len(5, PROTO_TCP), -1);
		add_packet(15, IP_V4, PROTO_TCP, 1'b1, 1'b1, full_len(15, PROTO_TCP), -1);
		add_packet(15, IP_V4, PROTO_UDP, 1'b1, 1'b1, 40, -1);
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b1, full_len(5, PROTO_TCP) - 1, -1);
		add_packet(6, IP_V4, PROTO_UDP, 1'b1, 1'b1, full_len(6, PROTO_UDP) - 1, -1);
		// tiny ihl puts the ports on top of the fixed header
		add_packet(0, IP_V4, PROTO_UDP, 1'b1, 1'b1, full_len(0, PROTO_UDP), -1);
		add_packet(1, IP_V4, PROTO_TCP, 1'b1, 1'b1, full_len(1, PROTO_TCP), -1);
		add_packet(4, IP_V4, PROTO_UDP, 1'b1, 1'b1, full_len(4, PROTO_UDP), -1);
		// all-ones and all-zeros headers, then an unshaped all-ones packet
		add_packet(15, IP_V4, PROTO_UDP, 1'b1, 1'b1, full_len(15, PROTO_UDP), 8'hFF);
		add_packet(5, IP_V4, 8'h00, 1'b1, 1'b1, full_len(5, 8'h00), 8'h00);
		add_packet(5, IP_V4, PROTO_TCP, 1'b1, 1'b0, 30, 8'hFF);

		set_link(LINK_ETH);
		add_link_checks();
		run_random(1, 20);

		set_link(LINK_VLAN);
		add_link_checks();
		run_random(1, 20);

		set_link(LINK_VLAN_ALT);
		run_random(2, 60);

		set_link(LINK_RAW);
		run_random(1, 20);

		set_link(LINK_VLAN);
		run_random(1, 20);

		// back to back at full rate to finish
		set_link(LINK_ETH);
		no_idle = 1'b1;
		run_random(2, 60);

		wait_idle();
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
		end
		$display("sent %0d bytes in %0d packets over raw, ethernet and both tagged link modes",
			bytes_accepted, packets_pushed);
		$display("checked %0d results, %0d kept and %0d dropped",
			results_seen, kept_seen, results_seen - kept_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
